// ----- rtl/rpds_pkg.sv -----
// Package for the ring period DMA sequencer: field widths, event, enable and
// status codes, and the packed result beat. No dependencies.
package rpds_pkg;

    localparam int POS_W  = 19;
    localparam int RING_W = 20;

    localparam logic [RING_W-1:0] RING_MIN  = 20'd8;
    localparam logic [RING_W-1:0] RING_MAX  = 20'd524288;
    localparam logic [POS_W-1:0]  CHUNK_MIN = 19'd8;
    localparam logic [POS_W-1:0]  CHUNK_MAX = 19'd262144;

    localparam logic [RING_W-1:0] BUFFER_BYTES_RESET = 20'd524288;
    localparam logic [POS_W-1:0]  PERIOD_BYTES_RESET = 19'd4096;

    // Four busy interrupts at most are tolerated while a stop drains.
    localparam logic [2:0] STOP_WAIT_LIMIT = 3'd5;

    typedef enum logic [1:0] {
        REQ_PREPARE   = 2'd0,
        REQ_START     = 2'd1,
        REQ_STOP      = 2'd2,
        REQ_INTERRUPT = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        EN_NONE    = 2'd0,
        EN_ENABLE  = 2'd1,
        EN_DISABLE = 2'd2
    } enable_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_SPURIOUS = 2'd2,
        ST_PHASE    = 2'd3
    } status_t;

    typedef enum logic {
        CFG_BUFFER_BYTES = 1'b0,
        CFG_PERIOD_BYTES = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic             dma_issue;
        logic [POS_W-1:0] dma_offset;
        logic [POS_W-1:0] dma_length;
        logic             zero_length_write;
        logic [1:0]       enable_write;
        logic             period_done;
        logic [POS_W-1:0] play_position;
        logic             draining;
        logic [1:0]       status_code;
    } result_t;

endpackage

// ----- rtl/ring_period_dma_sequencer.sv -----
// Ring period DMA sequencer: event decoding, chunk issue and queue tracking,
// with an output register and a skid stage. Depends on rpds_pkg.
//
// Channel | Direction | Handshake          | Beat contents
// --------+-----------+--------------------+-------------------------------------------
// in      | in        | in_valid/in_stall  | req_type, queue_full, engine_busy
// out     | out       | out_valid/out_stall| dma_issue ... status_code (one per event)
// cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (buffer/period bytes)
//
// Each accepted event beat is decoded in the cycle of its acceptance: the
// sequencer state is updated at that edge and the result beat is registered
// into the single output register, or into the skid stage while the output is
// stalled. One event is taken every cycle while in_stall is low. The skid
// stage lets one further beat in while a result is stalled, and in_stall
// rises only when both stages are full. Reset clears all sequencer state and
// loads the ring and period sizes with their defaults; cfg_ready is always high.
module ring_period_dma_sequencer (
    input  logic                       clk,
    input  logic                       rst_n,
    // event channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 req_type,
    input  logic                       queue_full,
    input  logic                       engine_busy,
    // result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       dma_issue,
    output logic [rpds_pkg::POS_W-1:0] dma_offset,
    output logic [rpds_pkg::POS_W-1:0] dma_length,
    output logic                       zero_length_write,
    output logic [1:0]                 enable_write,
    output logic                       period_done,
    output logic [rpds_pkg::POS_W-1:0] play_position,
    output logic                       draining,
    output logic [1:0]                 status_code,
    // configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [rpds_pkg::RING_W-1:0] cfg_data
);

    import rpds_pkg::*;

    // Configuration registers.
    logic [RING_W-1:0] buffer_bytes_reg;
    logic [POS_W-1:0]  period_bytes_reg;

    // Sequencer state.
    logic [POS_W-1:0] cur_pos_reg, cur_pos_next;
    logic [POS_W-1:0] queued_pos_reg, queued_pos_next;
    logic [POS_W-1:0] after_queued_pos_reg, after_queued_pos_next;
    logic [POS_W-1:0] wrap_remainder_reg, wrap_remainder_next;
    logic             queued_completes_reg, queued_completes_next;
    logic             after_queued_completes_reg, after_queued_completes_next;
    logic             playing_flag_reg, playing_flag_next;
    logic [2:0]       stop_count_reg, stop_count_next;
    logic             prepared_reg, prepared_next;

    // Output register and skid stage.
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    result_t result;

    logic in_accept;
    logic out_take;

    // Chunk issue datapath.
    logic [RING_W-1:0] ring;
    logic [POS_W-1:0]  period_clamped;
    logic [RING_W-1:0] chunk;
    logic [POS_W-1:0]  src_pos;
    logic [POS_W-1:0]  issue_pos;
    logic [RING_W-1:0] room;
    logic [RING_W-1:0] issue_len;
    logic [RING_W-1:0] issue_rem;
    logic [RING_W:0]   issue_end;
    logic [POS_W-1:0]  issue_next_pos;
    req_t              req;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign req       = req_t'(req_type);

    // Ring size clamped to its legal range; the period is clamped likewise
    // and never exceeds the ring.
    always_comb
    begin
        if (buffer_bytes_reg < RING_MIN)
            ring = RING_MIN;
        else if (buffer_bytes_reg > RING_MAX)
            ring = RING_MAX;
        else
            ring = buffer_bytes_reg;

        if (period_bytes_reg < CHUNK_MIN)
            period_clamped = CHUNK_MIN;
        else if (period_bytes_reg > CHUNK_MAX)
            period_clamped = CHUNK_MAX;
        else
            period_clamped = period_bytes_reg;

        if ({1'b0, period_clamped} > ring)
            chunk = ring;
        else
            chunk = {1'b0, period_clamped};
    end

    // The position a new chunk starts from. On an interrupt the queue first
    // shifts by one, so the chunk follows the old after-queued position.
    // A position left beyond the ring end by a size change restarts at zero.
    // A pending wrap remainder is issued whole at that position; otherwise
    // a full chunk is issued, cut at the ring end with the rest kept back.
    always_comb
    begin
        src_pos   = (req == REQ_INTERRUPT) ? after_queued_pos_reg : queued_pos_reg;
        issue_pos = ({1'b0, src_pos} >= ring) ? '0 : src_pos;
        room      = ring - {1'b0, issue_pos};
        issue_rem = '0;
        if (wrap_remainder_reg != '0)
        begin
            issue_len = {1'b0, wrap_remainder_reg};
        end
        else if (room < chunk)
        begin
            issue_len = room;
            issue_rem = chunk - room;
        end
        else
        begin
            issue_len = chunk;
        end
        issue_end      = {2'b00, issue_pos} + {1'b0, issue_len};
        issue_next_pos = (issue_end >= {1'b0, ring}) ? '0 : issue_end[POS_W-1:0];
    end

    // Event decode: next state and the result beat.
    always_comb
    begin
        cur_pos_next                = cur_pos_reg;
        queued_pos_next             = queued_pos_reg;
        after_queued_pos_next       = after_queued_pos_reg;
        wrap_remainder_next         = wrap_remainder_reg;
        queued_completes_next       = queued_completes_reg;
        after_queued_completes_next = after_queued_completes_reg;
        playing_flag_next           = playing_flag_reg;
        stop_count_next             = stop_count_reg;
        prepared_next               = prepared_reg;

        result                   = '0;
        result.enable_write      = EN_NONE;
        result.status_code       = ST_OK;

        case (req)
            REQ_PREPARE:
            begin
                cur_pos_next                = '0;
                queued_pos_next             = '0;
                after_queued_pos_next       = '0;
                wrap_remainder_next         = '0;
                queued_completes_next       = 1'b0;
                after_queued_completes_next = 1'b0;
                playing_flag_next           = 1'b0;
                stop_count_next             = '0;
                prepared_next               = 1'b1;
            end

            REQ_START:
            begin
                // A start while already playing is ignored.
                if (!playing_flag_reg)
                begin
                    result.enable_write = EN_ENABLE;
                    if (!prepared_reg)
                    begin
                        result.status_code = ST_SPURIOUS;
                    end
                    else if (queue_full)
                    begin
                        result.status_code = ST_FULL;
                    end
                    else
                    begin
                        result.dma_issue            = 1'b1;
                        result.dma_offset           = issue_pos;
                        result.dma_length           = issue_len[POS_W-1:0];
                        after_queued_pos_next       = issue_next_pos;
                        wrap_remainder_next         = issue_rem[POS_W-1:0];
                        after_queued_completes_next = (issue_rem == '0);
                        playing_flag_next           = 1'b1;
                        stop_count_next             = '0;
                    end
                end
            end

            REQ_STOP:
            begin
                // The zero length ends the queue after the chunk in flight.
                result.zero_length_write    = 1'b1;
                after_queued_pos_next       = queued_pos_reg;
                after_queued_completes_next = 1'b0;
                playing_flag_next           = 1'b0;
                stop_count_next             = 3'd1;
            end

            REQ_INTERRUPT:
            begin
                cur_pos_next          = queued_pos_reg;
                queued_pos_next       = after_queued_pos_reg;
                result.period_done    = queued_completes_reg;
                queued_completes_next = after_queued_completes_reg;

                if (stop_count_reg != '0)
                begin
                    // Draining after a stop: wait while the engine is busy,
                    // up to the limit, then disable.
                    if (engine_busy && stop_count_reg < STOP_WAIT_LIMIT)
                    begin
                        stop_count_next = stop_count_reg + 3'd1;
                    end
                    else
                    begin
                        result.enable_write = EN_DISABLE;
                        stop_count_next     = '0;
                        if (queued_pos_reg != after_queued_pos_reg)
                            result.status_code = ST_PHASE;
                    end
                end
                else if (!playing_flag_reg || !prepared_reg)
                begin
                    result.status_code = ST_SPURIOUS;
                end
                else if (queue_full)
                begin
                    result.status_code = ST_FULL;
                end
                else
                begin
                    result.dma_issue            = 1'b1;
                    result.dma_offset           = issue_pos;
                    result.dma_length           = issue_len[POS_W-1:0];
                    after_queued_pos_next       = issue_next_pos;
                    wrap_remainder_next         = issue_rem[POS_W-1:0];
                    after_queued_completes_next = (issue_rem == '0);
                end
            end

            default:
            begin
                result.status_code = ST_OK;
            end
        endcase

        result.play_position = cur_pos_next;
        result.draining      = (stop_count_next != '0);
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_bytes_reg <= BUFFER_BYTES_RESET;
            period_bytes_reg <= PERIOD_BYTES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BUFFER_BYTES: buffer_bytes_reg <= cfg_data;
                CFG_PERIOD_BYTES: period_bytes_reg <= cfg_data[POS_W-1:0];
                default:          buffer_bytes_reg <= buffer_bytes_reg;
            endcase
        end
    end

    // Sequencer state, updated on every accepted event.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pos_reg                <= '0;
            queued_pos_reg             <= '0;
            after_queued_pos_reg       <= '0;
            wrap_remainder_reg         <= '0;
            queued_completes_reg       <= 1'b0;
            after_queued_completes_reg <= 1'b0;
            playing_flag_reg           <= 1'b0;
            stop_count_reg             <= '0;
            prepared_reg               <= 1'b0;
        end
        else if (in_accept)
        begin
            cur_pos_reg                <= cur_pos_next;
            queued_pos_reg             <= queued_pos_next;
            after_queued_pos_reg       <= after_queued_pos_next;
            wrap_remainder_reg         <= wrap_remainder_next;
            queued_completes_reg       <= queued_completes_next;
            after_queued_completes_reg <= after_queued_completes_next;
            playing_flag_reg           <= playing_flag_next;
            stop_count_reg             <= stop_count_next;
            prepared_reg               <= prepared_next;
        end
    end

    // Output register and skid stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_take)
                    skid_valid_reg <= 1'b0;
            end
            else if (in_accept)
            begin
                if (!out_valid_reg || out_take)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result beats carry no reset.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_data_reg <= skid_data_reg;
        end
        else if (in_accept)
        begin
            if (!out_valid_reg || out_take)
                out_data_reg <= result;
            else
                skid_data_reg <= result;
        end
    end

    assign out_valid         = out_valid_reg;
    assign dma_issue         = out_data_reg.dma_issue;
    assign dma_offset        = out_data_reg.dma_offset;
    assign dma_length        = out_data_reg.dma_length;
    assign zero_length_write = out_data_reg.zero_length_write;
    assign enable_write      = out_data_reg.enable_write;
    assign period_done       = out_data_reg.period_done;
    assign play_position     = out_data_reg.play_position;
    assign draining          = out_data_reg.draining;
    assign status_code       = out_data_reg.status_code;

endmodule
